>>> hw/rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants, command codes, state codes and types of the bitmap run
// allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

   localparam int MAX_BITS   = 1024;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = $clog2(WORD_COUNT);
   localparam int BPOS_W     = $clog2(WORD_BITS);
   localparam int CMD_W      = 3;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_MARK       = 3'd0,
      CMD_CLEAR      = 3'd1,
      CMD_TEST       = 3'd2,
      CMD_FIND_MARK  = 3'd3,
      CMD_FIND_FIRST = 3'd4,
      CMD_FIND_LAST  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_BIT_MOD,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [BPOS_W-1:0] pos;
      logic [CNT_W-1:0]  run_out;
   } eval_type;

endpackage

>>> hw/rtl/bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// Bitmap allocator with single-bit mark/clear/test, find-and-mark of the
// lowest clear bit, and first/last search for a run of clear bits.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// beat follows, marked by rsp_strobe for one cycle, and cannot be held off.
// The map lives in a 32 x 32-bit RAM read one word per cycle. Mark, clear
// and test go through decode, read and modify/write before the strobe; an
// out-of-range index, a zero or oversized length for a run search and the
// unused codes are answered from decode. Searches stream the words through
// the single read port, one word per cycle, and end early when the run is
// found. busy falls in the strobe cycle. Reset and a write of num_bits
// clear the map at once through per-word valid flags; no clearing pass is
// needed. Write num_bits only while idle; 0 is taken as 1 and values above
// 1024 as 1024.
// ----------------------------------------------------------------------------
module bitmap_run_allocator
   import bra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [IDX_W-1:0]  req_bit_index,
   input  logic [CNT_W-1:0]  req_run_length,
   output logic              rsp_strobe,
   output logic              rsp_found,
   output logic [IDX_W-1:0]  rsp_result_index,
   output logic              rsp_bit_value,
   output logic [CNT_W-1:0]  rsp_free_count,
   output logic              rsp_index_error,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data
);

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       len_ff, len_in;
   logic [CNT_W-1:0]       scan_len_ff, scan_len_in;
   logic                   fwd_ff, fwd_in;
   logic [CNT_W-1:0]       num_bits_ff, num_bits_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [WORD_COUNT-1:0]  valid_ff, valid_in;
   logic [WADDR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [WADDR_W:0]       rd_left_ff, rd_left_in;
   logic [WADDR_W-1:0]     ev_addr_ff, ev_addr_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   ev_last_ff, ev_last_in;
   logic [CNT_W-1:0]       run_ff, run_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic                   rsp_bval_ff, rsp_bval_in;
   logic [CNT_W-1:0]       rsp_free_ff, rsp_free_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   ram_wr_en;
   logic [WADDR_W-1:0]     ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [WADDR_W-1:0]     ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;

   logic [WORD_BITS-1:0]   word_eff;
   logic [WORD_BITS-1:0]   scan_word;
   eval_type               eval;
   logic [WADDR_W-1:0]     top_word;
   logic [WADDR_W:0]       word_total;
   logic [BPOS_W-1:0]      hit_local;
   logic [IDX_W-1:0]       hit_glob;
   logic [CNT_W:0]         res_wide;
   logic                   bit_cur;
   logic                   accept;
   logic [CNT_W-1:0]       csr_clamped;

   bra_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bra_word_eval u_word_eval (
      .word_bits (scan_word),
      .carry_run (run_ff),
      .run_len   (scan_len_ff),
      .eval      (eval)
   );

   assign busy     = state_ff != ST_IDLE;
   assign accept   = start && !busy;
   assign word_eff = valid_ff[ev_addr_ff] ? ram_rd_data : '0;
   assign bit_cur  = word_eff[idx_ff[BPOS_W-1:0]];
   assign top_word = WADDR_W'((num_bits_ff - CNT_W'(1)) >> BPOS_W);
   assign word_total = {1'b0, top_word} + (WADDR_W+1)'(1);
   assign hit_local  = fwd_ff ? eval.pos : ~eval.pos;
   assign hit_glob   = IDX_W'({ev_addr_ff, hit_local});

   always_comb begin
      logic [BPOS_W-1:0]  p_local;
      logic [IDX_W-1:0]   p_glob;

      for (int j = 0; j < WORD_BITS; j++) begin
         p_local = fwd_ff ? BPOS_W'(j) : BPOS_W'(WORD_BITS - 1 - j);
         p_glob  = IDX_W'({ev_addr_ff, p_local});
         scan_word[j] = word_eff[p_local] || (CNT_W'(p_glob) >= num_bits_ff);
      end
   end

   always_comb begin
      if (fwd_ff) begin
         res_wide = (CNT_W+1)'(hit_glob) + (CNT_W+1)'(1) - (CNT_W+1)'(scan_len_ff);
      end else begin
         res_wide = (CNT_W+1)'(hit_glob) + (CNT_W+1)'(scan_len_ff) - (CNT_W+1)'(1);
      end
   end

   always_comb begin
      if (csr_wr_data == '0) begin
         csr_clamped = CNT_W'(1);
      end else if (csr_wr_data > CNT_W'(MAX_BITS)) begin
         csr_clamped = CNT_W'(MAX_BITS);
      end else begin
         csr_clamped = csr_wr_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      scan_len_in = scan_len_ff;
      fwd_in      = fwd_ff;
      num_bits_in = num_bits_ff;
      count_in    = count_ff;
      valid_in    = valid_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_left_in  = rd_left_ff;
      ev_addr_in  = ev_addr_ff;
      rd_vld_in   = 1'b0;
      ev_last_in  = ev_last_ff;
      run_in      = run_ff;

      rsp_strobe_in = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_index_in  = '0;
      rsp_bval_in   = 1'b0;
      rsp_err_in    = 1'b0;

      ram_wr_en   = 1'b0;
      ram_wr_addr = ev_addr_ff;
      ram_wr_data = word_eff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_command);
               idx_in   = req_bit_index;
               len_in   = req_run_length;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (cmd_ff)
               CMD_MARK, CMD_CLEAR, CMD_TEST: begin
                  if (CNT_W'(idx_ff) >= num_bits_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_err_in    = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = idx_ff[BPOS_W +: WADDR_W];
                     ev_addr_in  = idx_ff[BPOS_W +: WADDR_W];
                     state_in    = ST_BIT_MOD;
                  end
               end
               CMD_FIND_MARK, CMD_FIND_FIRST, CMD_FIND_LAST: begin
                  if (cmd_ff != CMD_FIND_MARK &&
                      (len_ff == '0 || len_ff > num_bits_ff)) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     scan_len_in = (cmd_ff == CMD_FIND_MARK) ? CNT_W'(1) : len_ff;
                     fwd_in      = cmd_ff != CMD_FIND_LAST;
                     rd_ptr_in   = (cmd_ff != CMD_FIND_LAST) ? '0 : top_word;
                     rd_left_in  = word_total;
                     run_in      = '0;
                     ev_last_in  = 1'b0;
                     state_in    = ST_SCAN;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end
         ST_BIT_MOD: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            unique case (cmd_ff)
               CMD_MARK: begin
                  if (!bit_cur) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = word_eff | (WORD_BITS'(1) << idx_ff[BPOS_W-1:0]);
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
               end
               CMD_CLEAR: begin
                  if (bit_cur) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = word_eff & ~(WORD_BITS'(1) << idx_ff[BPOS_W-1:0]);
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               default: begin
                  rsp_bval_in = bit_cur;
               end
            endcase
         end
         ST_SCAN: begin
            if (rd_left_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_ptr_ff;
               ev_addr_in  = rd_ptr_ff;
               rd_ptr_in   = fwd_ff ? rd_ptr_ff + WADDR_W'(1) : rd_ptr_ff - WADDR_W'(1);
               rd_left_in  = rd_left_ff - (WADDR_W+1)'(1);
               rd_vld_in   = 1'b1;
               ev_last_in  = rd_left_ff == (WADDR_W+1)'(1);
            end
            if (rd_vld_ff) begin
               run_in = eval.run_out;
               if (eval.hit) begin
                  rsp_strobe_in = 1'b1;
                  rsp_found_in  = 1'b1;
                  rsp_index_in  = res_wide[IDX_W-1:0];
                  rd_vld_in     = 1'b0;
                  state_in      = ST_IDLE;
                  if (cmd_ff == CMD_FIND_MARK) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = word_eff | (WORD_BITS'(1) << hit_local);
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
               end else if (ev_last_ff) begin
                  rsp_strobe_in = 1'b1;
                  rd_vld_in     = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end

      rsp_free_in = count_in;

      if (csr_wr_en) begin
         num_bits_in = csr_clamped;
         count_in    = csr_clamped;
         valid_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_bits_ff   <= CNT_W'(MAX_BITS);
         count_ff      <= CNT_W'(MAX_BITS);
         valid_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_bits_ff   <= num_bits_in;
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      len_ff       <= len_in;
      scan_len_ff  <= scan_len_in;
      fwd_ff       <= fwd_in;
      rd_ptr_ff    <= rd_ptr_in;
      rd_left_ff   <= rd_left_in;
      ev_addr_ff   <= ev_addr_in;
      ev_last_ff   <= ev_last_in;
      run_ff       <= run_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_bval_ff  <= rsp_bval_in;
      rsp_free_ff  <= rsp_free_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_bit_value    = rsp_bval_ff;
   assign rsp_free_count   = rsp_free_ff;
   assign rsp_index_error  = rsp_err_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accepted beat");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a command in flight");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_index_error) |-> (!rsp_found && !rsp_bit_value))
      else $error("index error beat carries search or test data");

   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_len_ff != '0))
      else $error("scan running with zero run length");

endmodule

>>> hw/rtl/bra_ram.sv
// ----------------------------------------------------------------------------
// bra_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bra_word_eval.sv
// ----------------------------------------------------------------------------
// bra_word_eval
// Evaluates one map word in scan order: run of clear bits ending at each
// position, lowest position whose run reaches the sought length, and the
// run carried into the next word.
// ----------------------------------------------------------------------------
module bra_word_eval
   import bra_pkg::*;
(
   input  logic [WORD_BITS-1:0] word_bits,
   input  logic [CNT_W-1:0]     carry_run,
   input  logic [CNT_W-1:0]     run_len,
   output eval_type             eval
);

   always_comb begin
      logic [BPOS_W-1:0]    last_pos;
      logic                 any_set;
      logic [CNT_W:0]       run_j;
      logic [CNT_W:0]       run_last;
      logic [WORD_BITS-1:0] hit_vec;

      run_last = '0;
      hit_vec  = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         any_set  = 1'b0;
         last_pos = '0;
         for (int k = 0; k < WORD_BITS; k++) begin
            if (k <= j && word_bits[k]) begin
               any_set  = 1'b1;
               last_pos = BPOS_W'(k);
            end
         end
         if (any_set) begin
            run_j = (CNT_W+1)'(j) - (CNT_W+1)'(last_pos);
         end else begin
            run_j = {1'b0, carry_run} + (CNT_W+1)'(j + 1);
         end
         hit_vec[j] = run_j >= {1'b0, run_len};
         if (j == WORD_BITS - 1) begin
            run_last = run_j;
         end
      end

      eval.hit     = |hit_vec;
      eval.pos     = '0;
      eval.run_out = run_last[CNT_W-1:0];
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            eval.pos = BPOS_W'(j);
         end
      end
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap run allocator. Commands go in on the
// start/busy handshake with random idle gaps. A scoreboard keeps its own copy
// of the map, the map size and the free count. It predicts every result beat
// and compares the beats field by field in order. The map size register is
// rewritten between phases, extremes included. Each phase mixes fill bursts,
// hole punching with matched run searches, and random commands.
// ----------------------------------------------------------------------------
module tb_top
   import bra_pkg::*;
();

   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          ITEM_TARGET  = 1850;
   localparam int          PHASES       = 14;
   localparam bit [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam bit [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] result_index;
      logic             bit_value;
      logic [CNT_W-1:0] free_count;
      logic             index_error;
   } alloc_result_type;

   class alloc_scoreboard;
      bit [MAX_BITS-1:0] used_map;
      int unsigned       map_size;
      int unsigned       free_bits;
      alloc_result_type  expected_q[$];
      int unsigned       mismatches;
      int unsigned       checked;
      int unsigned       hits;

      function new();
         map_size   = MAX_BITS;
         free_bits  = MAX_BITS;
         used_map   = '0;
         mismatches = 0;
         checked    = 0;
         hits       = 0;
      endfunction

      function void resize(bit [CNT_W-1:0] value);
         int unsigned n;
         n = value;
         if (n == 0) n = 1;
         if (n > MAX_BITS) n = MAX_BITS;
         map_size  = n;
         free_bits = n;
         used_map  = '0;
      endfunction

      function void note_command(bit [CMD_W-1:0] cmd, bit [IDX_W-1:0] idx,
                                 bit [CNT_W-1:0] len);
         alloc_result_type r;
         int unsigned      run;
         r   = '0;
         run = 0;
         case (cmd)
            CMD_MARK, CMD_CLEAR, CMD_TEST: begin
               if (idx >= map_size) begin
                  r.index_error = 1'b1;
               end else if (cmd == CMD_MARK) begin
                  if (!used_map[idx]) begin
                     used_map[idx] = 1'b1;
                     if (free_bits > 0) free_bits--;
                  end
               end else if (cmd == CMD_CLEAR) begin
                  if (used_map[idx]) begin
                     used_map[idx] = 1'b0;
                     free_bits++;
                  end
               end else begin
                  r.bit_value = used_map[idx];
               end
            end
            CMD_FIND_MARK: begin
               for (int i = 0; i < map_size; i++) begin
                  if (!used_map[i]) begin
                     used_map[i] = 1'b1;
                     if (free_bits > 0) free_bits--;
                     r.found        = 1'b1;
                     r.result_index = IDX_W'(i);
                     break;
                  end
               end
            end
            CMD_FIND_FIRST: begin
               if (len != 0 && len <= map_size) begin
                  for (int i = 0; i < map_size; i++) begin
                     run = used_map[i] ? 0 : run + 1;
                     if (run >= len) begin
                        r.found        = 1'b1;
                        r.result_index = IDX_W'(i + 1 - len);
                        break;
                     end
                  end
               end
            end
            CMD_FIND_LAST: begin
               if (len != 0 && len <= map_size) begin
                  for (int i = map_size; i > 0; i--) begin
                     run = used_map[i-1] ? 0 : run + 1;
                     if (run >= len) begin
                        r.found        = 1'b1;
                        r.result_index = IDX_W'(i - 1 + len - 1);
                        break;
                     end
                  end
               end
            end
            default: ;
         endcase
         r.free_count = free_bits[CNT_W-1:0];
         expected_q.push_back(r);
      endfunction

      function void compare_field(string label, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(alloc_result_type got);
         alloc_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result beat with nothing outstanding, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.found) hits++;
         compare_field("found", 16'(want.found), 16'(got.found));
         compare_field("result_index", 16'(want.result_index), 16'(got.result_index));
         compare_field("bit_value", 16'(want.bit_value), 16'(got.bit_value));
         compare_field("free_count", 16'(want.free_count), 16'(got.free_count));
         compare_field("index_error", 16'(want.index_error), 16'(got.index_error));
      endfunction
   endclass

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             start          = 1'b0;
   logic             busy;
   logic [CMD_W-1:0] req_command    = '0;
   logic [IDX_W-1:0] req_bit_index  = '0;
   logic [CNT_W-1:0] req_run_length = '0;
   logic             rsp_strobe;
   logic             rsp_found;
   logic [IDX_W-1:0] rsp_result_index;
   logic             rsp_bit_value;
   logic [CNT_W-1:0] rsp_free_count;
   logic             rsp_index_error;
   logic             csr_wr_en      = 1'b0;
   logic [CNT_W-1:0] csr_wr_data    = '0;

   alloc_scoreboard book = new();
   bit              idle_on = 1'b1;
   int unsigned     sent = 0;
   int unsigned     size_writes = 0;
   int unsigned     cycles = 0;

   bitmap_run_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_bit_index    (req_bit_index),
      .req_run_length   (req_run_length),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_result_index (rsp_result_index),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_free_count   (rsp_free_count),
      .rsp_index_error  (rsp_index_error),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         book.check_result(alloc_result_type'({rsp_found, rsp_result_index, rsp_bit_value,
                                               rsp_free_count, rsp_index_error}));
      end
   end

   // returns at the edge that accepts the beat; start is left high
   task automatic issue(bit [CMD_W-1:0] cmd, bit [IDX_W-1:0] idx, bit [CNT_W-1:0] len);
      if (idle_on && $urandom_range(0, 99) < 14) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_bit_index  <= idx;
      req_run_length <= len;
      do @(posedge clock); while (busy);
      book.note_command(cmd, idx, len);
      sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      while (book.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_size(bit [CNT_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      book.resize(value);
      csr_wr_en <= 1'b0;
      size_writes++;
   endtask

   function automatic bit [IDX_W-1:0] pick_index(int unsigned span);
      if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 1023));
      return IDX_W'($urandom_range(0, span - 1));
   endfunction

   function automatic bit [CNT_W-1:0] pick_length(int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return CNT_W'($urandom_range(span, span + 1));
      if (r < 15) return CNT_W'($urandom_range(1025, 2047));
      if (r < 40) return CNT_W'($urandom_range(1, span));
      return CNT_W'($urandom_range(1, span < 16 ? span : 16));
   endfunction

   task automatic random_command(int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20)      issue(CMD_MARK, pick_index(span), pick_length(span));
      else if (r < 38) issue(CMD_CLEAR, pick_index(span), pick_length(span));
      else if (r < 50) issue(CMD_TEST, pick_index(span), pick_length(span));
      else if (r < 64) issue(CMD_FIND_MARK, pick_index(span), pick_length(span));
      else if (r < 79) issue(CMD_FIND_FIRST, pick_index(span), pick_length(span));
      else if (r < 97) issue(CMD_FIND_LAST, pick_index(span), pick_length(span));
      else issue(r[0] ? CMD_SPARE_HI : CMD_SPARE_LO, pick_index(span), pick_length(span));
   endtask

   // clear a short stretch, then look for a run of exactly that width
   task automatic punch_hole(int unsigned span);
      int unsigned base;
      int unsigned width;
      base  = $urandom_range(0, span - 1);
      width = $urandom_range(1, span < 12 ? span : 12);
      for (int j = 0; j < width; j++) issue(CMD_CLEAR, IDX_W'(base + j), '0);
      issue(CMD_FIND_FIRST, pick_index(span), CNT_W'(width));
      issue(CMD_FIND_LAST, pick_index(span), CNT_W'(width));
   endtask

   task automatic run_directed();
      issue(CMD_TEST, 10'd0, 11'd0);
      issue(CMD_MARK, 10'd0, 11'd0);
      issue(CMD_MARK, 10'd0, 11'd0);
      issue(CMD_TEST, 10'd0, 11'd0);
      issue(CMD_CLEAR, 10'd1023, 11'd0);
      issue(CMD_MARK, 10'd1023, 11'd2047);
      issue(CMD_FIND_FIRST, 10'd0, 11'd0);
      issue(CMD_FIND_LAST, 10'd0, 11'd0);
      issue(CMD_FIND_FIRST, 10'd0, 11'd1024);
      issue(CMD_FIND_LAST, 10'd0, 11'd1);
      issue(CMD_FIND_LAST, 10'd0, 11'd1022);
      issue(CMD_FIND_FIRST, 10'd0, 11'd1023);
      issue(CMD_FIND_FIRST, 10'd0, 11'd2047);
      issue(CMD_FIND_MARK, 10'd1023, 11'd0);
      issue(CMD_SPARE_LO, 10'd1023, 11'd2047);
      issue(CMD_SPARE_HI, 10'd0, 11'd1);
      write_size(11'd3);
      issue(CMD_MARK, 10'd3, 11'd0);
      issue(CMD_TEST, 10'd1023, 11'd0);
      repeat (4) issue(CMD_FIND_MARK, 10'd0, 11'd0);
      issue(CMD_FIND_FIRST, 10'd0, 11'd1);
      issue(CMD_CLEAR, 10'd1, 11'd0);
      issue(CMD_FIND_LAST, 10'd0, 11'd1);
   endtask

   task automatic run_random();
      int unsigned fixed_sizes[10] = '{MAX_BITS, 40, 1, 0, 7, 2047, 64, 1025, 33, 512};
      int unsigned quota;
      int unsigned first;
      int unsigned raw;
      int unsigned span;
      quota = ITEM_TARGET / PHASES;
      first = sent;
      for (int p = 0; p < PHASES; p++) begin
         raw  = (p < 10) ? fixed_sizes[p] : $urandom_range(0, 2047);
         write_size(CNT_W'(raw));
         span = book.map_size;
         repeat ($urandom_range(0, span < 100 ? span : 100)) begin
            issue(CMD_FIND_MARK, pick_index(span), pick_length(span));
         end
         while (sent - first < (p + 1) * quota) begin
            // one long stretch of back-to-back beats
            idle_on = !(sent - first >= 600 && sent - first < 900);
            if ($urandom_range(0, 99) < 15) punch_hole(span);
            else random_command(span);
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      settle();
      repeat (40) @(posedge clock);
      $display("summary: %0d commands over %0d map size writes, %0d results checked",
               sent, size_writes, book.checked);
      $display("summary: %0d finds succeeded, %0d mismatches", book.hits, book.mismatches);
      if (book.mismatches == 0 && book.expected_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
